// ===== rtl/gsm7_septet_unpacker_latin1_top_macros.svh =====
// Assertion macros for the GSM 7-bit unpacker.
`ifndef GSM7_SEPTET_UNPACKER_LATIN1_TOP_MACROS_SVH
`define GSM7_SEPTET_UNPACKER_LATIN1_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled in reset.
`define GSM7U_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define GSM7U_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GSM7U_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define GSM7U_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/gsm7u_pkg.sv =====
// Types, constants and alphabet tables for the GSM 7-bit unpacker.
package gsm7u_pkg;

    localparam logic [6:0] ESC_SEPTET  = 7'h1b;
    localparam logic [7:0] SEPTET_MASK = 8'h7f;
    localparam int         RES_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] octet;
        logic       start_req;
        logic [7:0] message_septets;
    } in_word_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } out_word_t;

    // Up to two characters per octet, packed to the front.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  r0;
        out_word_t  r1;
    } res_pair_t;

    typedef struct packed {
        logic       esc_pending;
        logic       msg_idle;
        logic [2:0] phase;
    } unp_status_t;

    typedef struct packed {
        logic       emit;
        out_word_t  word;
        logic       esc_next;
        logic [7:0] left_next;
    } sept_res_t;

    function automatic logic [7:0] base_char(input logic [6:0] s);
        logic [7:0] c;
        case (s)
            7'h00: c = 8'h40; 7'h01: c = 8'ha3; 7'h02: c = 8'h24; 7'h03: c = 8'ha5;
            7'h04: c = 8'he8; 7'h05: c = 8'he9; 7'h06: c = 8'hf9; 7'h07: c = 8'hec;
            7'h08: c = 8'hf2; 7'h09: c = 8'hc7; 7'h0a: c = 8'h0a; 7'h0b: c = 8'hd8;
            7'h0c: c = 8'hf8; 7'h0d: c = 8'h0d; 7'h0e: c = 8'hc5; 7'h0f: c = 8'he5;
            7'h11: c = 8'h5f;
            7'h1c: c = 8'hc6; 7'h1d: c = 8'he6; 7'h1e: c = 8'hdf; 7'h1f: c = 8'hc9;
            7'h24: c = 8'ha4;
            7'h40: c = 8'ha1;
            7'h5b: c = 8'hc4; 7'h5c: c = 8'hd6; 7'h5d: c = 8'hd1; 7'h5e: c = 8'hdc;
            7'h5f: c = 8'ha7;
            7'h60: c = 8'hbf;
            7'h7b: c = 8'he4; 7'h7c: c = 8'hf6; 7'h7d: c = 8'hf1; 7'h7e: c = 8'hfc;
            7'h7f: c = 8'he0;
            default: begin
                // ASCII-identical rows; control range 0x10..0x1b is unmapped except 0x11
                if (s >= 7'h20) c = {1'b0, s};
                else            c = 8'h00;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ext_char(input logic [6:0] s);
        logic [7:0] c;
        case (s)
            7'h0a:   c = 8'h0c;
            7'h14:   c = 8'h5e;
            7'h28:   c = 8'h7b;
            7'h29:   c = 8'h7d;
            7'h2f:   c = 8'h5c;
            7'h3c:   c = 8'h5b;
            7'h3d:   c = 8'h7e;
            7'h3e:   c = 8'h5d;
            7'h40:   c = 8'h7c;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/gsm7u_unpack.sv =====
// Septet unpacking state and per-octet character decode.
module gsm7u_unpack (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  gsm7u_pkg::in_word_t      in_word,
    output gsm7u_pkg::res_pair_t     res,
    output gsm7u_pkg::unp_status_t   status
);
    import gsm7u_pkg::*;

    logic [6:0] lo_reg,    lo_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] left_reg,  left_next;
    logic       esc_reg,   esc_next;

    logic [6:0]  lo_s;
    logic [2:0]  ph_s;
    logic [7:0]  left_s;
    logic        esc_s;
    logic [14:0] shifted;
    logic [6:0]  first_sep;
    logic [6:0]  carry_bits;
    logic        second_due;
    sept_res_t   t1, t2;

    // One septet through the alphabet, escape handling and count.
    function automatic sept_res_t take(input logic [6:0] s, input logic [7:0] left,
                                       input logic esc);
        sept_res_t r;
        logic      fin;
        r.emit           = 1'b0;
        r.word.character = 8'h00;
        r.word.last      = 1'b0;
        r.esc_next       = esc;
        r.left_next      = left;
        fin              = (left == 8'd1);
        if (left != 8'd0) begin
            r.left_next = left - 8'd1;
            r.word.last = fin;
            if (esc) begin
                r.emit           = 1'b1;
                r.word.character = ext_char(s);
                r.esc_next       = 1'b0;
            end else if (s == ESC_SEPTET) begin
                // dangling escape at the end gives a zero character
                r.emit     = fin;
                r.esc_next = !fin;
            end else begin
                r.emit           = 1'b1;
                r.word.character = base_char(s);
            end
        end
        return r;
    endfunction

    always_comb begin
        if (in_word.start_req) begin
            lo_s   = '0;
            ph_s   = '0;
            esc_s  = 1'b0;
            left_s = in_word.message_septets;
        end else begin
            lo_s   = lo_reg;
            ph_s   = (phase_reg > 3'd6) ? 3'd0 : phase_reg;
            esc_s  = esc_reg;
            left_s = left_reg;
        end

        shifted    = {7'b0, in_word.octet} << ph_s;
        first_sep  = shifted[6:0] | lo_s;
        carry_bits = shifted[13:7];
        second_due = (ph_s == 3'd6);

        t1 = take(first_sep, left_s, esc_s);
        t2 = take(carry_bits, t1.left_next, t1.esc_next);
        if (!second_due) t2.emit = 1'b0;

        res.count = {1'b0, t1.emit} + {1'b0, t2.emit};
        res.r0    = t1.emit ? t1.word : t2.word;
        res.r1    = t2.word;

        if (left_s == 8'd0) begin
            res.count  = 2'd0;
            lo_next    = lo_s;
            phase_next = ph_s;
            esc_next   = esc_s;
            left_next  = left_s;
        end else if (second_due) begin
            lo_next    = '0;
            phase_next = '0;
            esc_next   = t2.esc_next;
            left_next  = t2.left_next;
        end else begin
            lo_next    = carry_bits;
            phase_next = ph_s + 3'd1;
            esc_next   = t1.esc_next;
            left_next  = t1.left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg    <= '0;
            phase_reg <= '0;
            left_reg  <= '0;
            esc_reg   <= 1'b0;
        end else if (accept) begin
            lo_reg    <= lo_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
            esc_reg   <= esc_next;
        end
    end

    assign status.esc_pending = esc_reg;
    assign status.msg_idle    = (left_reg == 8'd0);
    assign status.phase       = phase_reg;

endmodule

// ===== rtl/gsm7_septet_unpacker_latin1_top.sv =====
// Top level of the GSM 7-bit septet unpacker with Latin-1 output.
//
// Usage:
//   s_* channel takes one packed user-data word per handshake: the octet,
//   start_req (set on the first octet of a message, loads message_septets
//   and clears the unpacking state) and the septet count.
//   m_* channel delivers one decoded Latin-1 character per word; last marks
//   the character made from the message's final septet.
// Decode: an octet's characters enter the result queue when it is
//   accepted (state and decode are one combinational pass at acceptance).
// Throughput: one octet per cycle while s_ready is high; every seventh
//   octet of a message can yield two characters, so sustained input is
//   bounded by the output port at one character per cycle. The result
//   queue (RES_DEPTH words) sets how many octets can be taken ahead of a
//   slow receiver.
// Stall: when m_ready is low, results wait in the queue; s_ready drops
//   once fewer than two free slots remain.
// Reset: synchronous on aresetn low; queue emptied, no message active.
//   Octets with no active message and no start_req give no characters.
`include "gsm7_septet_unpacker_latin1_top_macros.svh"

module gsm7_septet_unpacker_latin1_top #(
    parameter int RES_DEPTH = gsm7u_pkg::RES_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gsm7u_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gsm7u_pkg::out_word_t  m_data
);
    import gsm7u_pkg::*;

    localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int CNT_W = $clog2(RES_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RES_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(RES_DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(RES_DEPTH);

    logic        s_take;
    logic        m_take;
    res_pair_t   pair;
    unp_status_t unp_st;

    // result queue
    out_word_t        q_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_plus1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign s_ready = (cnt_reg <= CNT_ROOM2);
    assign s_take  = s_valid && s_ready;
    assign m_valid = (cnt_reg != '0);
    assign m_take  = m_valid && m_ready;
    assign m_data  = q_reg[rd_reg];

    gsm7u_unpack u_unpack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_take),
        .in_word (s_data),
        .res     (pair),
        .status  (unp_st)
    );

    always_comb begin
        logic [1:0] n_push;
        n_push   = s_take ? pair.count : 2'd0;
        wr_plus1 = ptr_inc(wr_reg);
        case (n_push)
            2'd0:    wr_next = wr_reg;
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = ptr_inc(wr_plus1);
            default: wr_next = wr_reg;
        endcase
        rd_next  = m_take ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(n_push) - CNT_W'(m_take);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge aclk) begin
        if (s_take && (pair.count != 2'd0)) begin
            q_reg[wr_reg] <= pair.r0;
        end
        if (s_take && (pair.count == 2'd2)) begin
            q_reg[wr_plus1] <= pair.r1;
        end
    end

    `GSM7U_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_FULL, "queue overflow")
    `GSM7U_ASSERT_NXT(a_push_fits, aclk, aresetn, s_take && (pair.count == 2'd2) && !m_take, cnt_reg >= 2, "double push lost")
    `GSM7U_ASSERT_IMP(a_esc_active, aclk, aresetn, unp_st.esc_pending, !unp_st.msg_idle, "escape pending with no message")
    `GSM7U_ASSERT_IMP(a_phase_range, aclk, aresetn, 1'b1, unp_st.phase <= 3'd6, "bit phase out of range")

endmodule

// ===== bench/gsm7_septet_unpacker_latin1_top_test.sv =====
// Self-checking testbench for the GSM 7-bit septet unpacker with Latin-1 output.
module gsm7_septet_unpacker_latin1_top_test;
    import gsm7u_pkg::*;

    typedef logic [6:0] septet_q_t[$];

    // Run limit in clock cycles.
    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_WORDS = 1450;
    localparam int HOLD_CYCLES  = 400;

    // GSM default alphabet to Latin-1, indexed by septet. Entries with no
    // Latin-1 form (Greek capitals, the escape code) decode as 0.
    localparam logic [0:127][7:0] BASE_LATIN1 = {
        8'h40, 8'ha3, 8'h24, 8'ha5, 8'he8, 8'he9, 8'hf9, 8'hec,
        8'hf2, 8'hc7, 8'h0a, 8'hd8, 8'hf8, 8'h0d, 8'hc5, 8'he5,
        8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'hc6, 8'he6, 8'hdf, 8'hc9,
        8'h20, 8'h21, 8'h22, 8'h23, 8'ha4, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
        8'ha1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
        8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'h59, 8'h5a, 8'hc4, 8'hd6, 8'hd1, 8'hdc, 8'ha7,
        8'hbf, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
        8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
        8'h78, 8'h79, 8'h7a, 8'he4, 8'hf6, 8'hf1, 8'hfc, 8'he0
    };

    // Extension table, used for the septet that follows an escape.
    // Only nine codes are defined; everything else decodes as 0.
    localparam logic [0:127][7:0] EXT_LATIN1 = {
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h0c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h5e, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h7b, 8'h7d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h5b, 8'h7e, 8'h5d, 8'h00,
        8'h7c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Defined extension codes, so random text hits them often.
    localparam logic [0:8][6:0] EXT_CODES = {
        7'h0a, 7'h14, 7'h28, 7'h29, 7'h2f, 7'h3c, 7'h3d, 7'h3e, 7'h40
    };

    // Unpacks accepted octet words into the characters the block must emit,
    // and checks each emitted character against the oldest one due.
    class latin1_scoreboard;
        logic [6:0] carry_bits;
        logic [2:0] bit_phase;
        logic [7:0] septets_left;
        bit         esc_pending;
        out_word_t  chars_due[$];
        int         fail_count;
        int         chars_checked;
        int         words_taken;
        int         messages_started;
        int         escapes_decoded;

        function new();
            carry_bits       = '0;
            bit_phase        = '0;
            septets_left     = '0;
            esc_pending      = 1'b0;
            fail_count       = 0;
            chars_checked    = 0;
            words_taken      = 0;
            messages_started = 0;
            escapes_decoded  = 0;
        endfunction

        task report(input string what);
            if (fail_count < 40)
                $display("MISMATCH @%0t: %s", $realtime, what);
            fail_count++;
        endtask

        function void decode_septet(input logic [6:0] s);
            out_word_t w;
            bit        final_one;
            bit        emit;
            if (septets_left == 8'd0)
                return;
            septets_left = septets_left - 8'd1;
            final_one    = (septets_left == 8'd0);
            emit         = 1'b1;
            w.character  = 8'h00;
            if (esc_pending) begin
                w.character = EXT_LATIN1[s];
                esc_pending = 1'b0;
                escapes_decoded++;
            end else if (s == ESC_SEPTET) begin
                // an escape that ends the message decodes as 0
                if (!final_one) begin
                    esc_pending = 1'b1;
                    emit        = 1'b0;
                end
            end else begin
                w.character = BASE_LATIN1[s];
            end
            w.last = final_one;
            if (emit)
                chars_due.push_back(w);
        endfunction

        function void note_word(input in_word_t w);
            logic [15:0] shifted;
            logic [6:0]  first;
            logic [3:0]  ph;
            words_taken++;
            if (w.start_req) begin
                carry_bits   = '0;
                bit_phase    = '0;
                esc_pending  = 1'b0;
                septets_left = w.message_septets;
                messages_started++;
            end
            if (septets_left == 8'd0)
                return;
            ph         = (bit_phase > 3'd6) ? 4'd0 : {1'b0, bit_phase};
            shifted    = {8'h00, w.octet} << ph;
            first      = shifted[6:0] | carry_bits;
            carry_bits = 7'(w.octet >> (4'd7 - ph));
            ph         = ph + 4'd1;
            decode_septet(first);
            if (ph == 4'd7) begin
                decode_septet(carry_bits);
                carry_bits = '0;
                ph         = 4'd0;
            end
            bit_phase = ph[2:0];
        endfunction

        task check_char(input out_word_t got);
            out_word_t want;
            if (chars_due.size() == 0) begin
                report($sformatf("character %02h last %0b with none due",
                                 got.character, got.last));
                return;
            end
            want = chars_due.pop_front();
            chars_checked++;
            if (got.character !== want.character)
                report($sformatf("character %02h, want %02h",
                                 got.character, want.character));
            if (got.last !== want.last)
                report($sformatf("last %0b on character %02h, want %0b",
                                 got.last, got.character, want.last));
        endtask

        task close_out();
            if (chars_due.size() != 0)
                report($sformatf("%0d characters never arrived", chars_due.size()));
        endtask
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int        cycle_count = 0;
    in_word_t  octet_words[$];
    int        random_words;
    latin1_scoreboard charbook;

    gsm7_septet_unpacker_latin1_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 20-unit clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Both monitors sample at the clock edge, before any update of that edge
    // lands, so they see exactly the values the block saw.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            charbook.note_word(s_data);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            charbook.check_char(m_data);
    end

    // Packs septets LSB first, the way they sit in SMS user data. Bits past
    // the last septet are random padding. keep_words < 0 sends the whole
    // message; otherwise it is cut short after keep_words octets, which
    // leaves the block mid-message for whatever follows.
    task automatic queue_message(input septet_q_t sept, input int keep_words,
                                 input bit counted);
        in_word_t   w;
        logic [7:0] oc;
        int         n_oct;
        int         i;
        int         b;
        int         bitpos;
        n_oct = (7 * sept.size() + 7) / 8;
        if (n_oct == 0)
            n_oct = 1;
        if (keep_words >= 0 && keep_words < n_oct)
            n_oct = keep_words;
        for (i = 0; i < n_oct; i++) begin
            oc = 8'($urandom);
            for (b = 0; b < 8; b++) begin
                bitpos = 8 * i + b;
                if (bitpos / 7 < sept.size())
                    oc[b] = sept[bitpos / 7][bitpos % 7];
            end
            w.octet           = oc;
            w.start_req       = (i == 0);
            // the count field is don't-care after the first word: randomize it
            w.message_septets = (i == 0) ? 8'(sept.size()) : 8'($urandom);
            octet_words.push_back(w);
            if (counted)
                random_words++;
        end
    endtask

    // Words with start_req low; ignored unless a message is still open.
    task automatic queue_noise(input int n);
        in_word_t w;
        int       i;
        for (i = 0; i < n; i++) begin
            w.octet           = 8'($urandom);
            w.start_req       = 1'b0;
            w.message_septets = 8'($urandom);
            octet_words.push_back(w);
        end
    endtask

    // Random text, heavy on escapes and on the defined extension codes.
    function automatic septet_q_t random_text(input int n);
        septet_q_t q;
        int        i;
        bit        after_esc;
        after_esc = 1'b0;
        for (i = 0; i < n; i++) begin
            if (after_esc && $urandom_range(0, 1) == 0)
                q.push_back(EXT_CODES[$urandom_range(0, 8)]);
            else if ($urandom_range(0, 6) == 0)
                q.push_back(ESC_SEPTET);
            else
                q.push_back(7'($urandom));
            after_esc = (q[q.size() - 1] == ESC_SEPTET);
        end
        return q;
    endfunction

    task automatic build_directed();
        in_word_t w;
        // octet with no message open: dropped, count field at its maximum
        w.octet           = 8'hff;
        w.start_req       = 1'b0;
        w.message_septets = 8'hff;
        octet_words.push_back(w);
        // zero-length message, all-zero octet, then a stray octet it must drop
        w.octet           = 8'h00;
        w.start_req       = 1'b1;
        w.message_septets = 8'h00;
        octet_words.push_back(w);
        queue_noise(1);
        // first octet is 0xff; escape then escape, escape then form feed;
        // eight septets so the seventh octet carries two characters
        queue_message('{7'h7f, 7'h01, 7'h00, 7'h1b, 7'h1b, 7'h1b, 7'h0a, 7'h41}, -1, 1'b0);
        // escape as the final septet
        queue_message('{7'h41, 7'h1b}, -1, 1'b0);
        // escape left pending when a new message starts over it; the new
        // message's opening '<' must use the base table
        queue_message('{7'h1b, 7'h3c, 7'h41}, 1, 1'b0);
        queue_message('{7'h3c, 7'h14}, -1, 1'b0);
        // maximum count, abandoned after three octets, then a one-septet message
        queue_message(random_text(255), 3, 1'b0);
        queue_message('{7'h7f}, -1, 1'b0);
        // trailing octets after a complete message are dropped
        queue_noise(2);
    endtask

    task automatic build_random();
        int kind;
        int len;
        int msg_idx;
        msg_idx = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (msg_idx == 2 || $urandom_range(0, 49) == 0)
                len = $urandom_range(200, 255);
            else if ($urandom_range(0, 19) == 0)
                len = 0;
            else
                len = $urandom_range(1, 40);
            if (kind < 7) begin
                queue_noise($urandom_range(1, 3));
            end else if (kind < 17) begin
                // cut short; the next message starts over it
                queue_message(random_text(len), $urandom_range(1, 8), 1'b1);
            end else begin
                queue_message(random_text(len), -1, 1'b1);
                if ($urandom_range(0, 9) == 0)
                    queue_noise($urandom_range(1, 2));
            end
            msg_idx++;
        end
    endtask

    // Sender: bursts of back-to-back words separated by idle gaps. Valid
    // holds with a stable word until accepted.
    task automatic drive_words();
        int burst_left;
        int gap;
        in_word_t w;
        burst_left = $urandom_range(1, 30);
        while (octet_words.size() != 0) begin
            w = octet_words.pop_front();
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                gap = $urandom_range(1, 7);
                repeat (gap) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 25);
            end
            s_valid <= 1'b1;
            s_data  <= w;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            burst_left--;
        end
        s_valid <= 1'b0;
    endtask

    // Receiver: segments of differing stall density, and once a long
    // hold-off so the result queue fills and s_ready drops.
    initial begin : receiver
        int seg;
        int mode;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && cycle_count > 700) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end
            seg  = $urandom_range(5, 60);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 7) != 0);
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    initial begin : main_seq
        charbook = new();
        build_directed();
        build_random();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        drive_words();
        // drain, then wait on to catch stray characters
        while (charbook.chars_due.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        charbook.close_out();
        $display("Covered %0d octet words over %0d message starts, %0d characters checked",
                 charbook.words_taken, charbook.messages_started, charbook.chars_checked);
        $display("(%0d via the extension table), with a long receiver hold-off.",
                 charbook.escapes_decoded);
        if (charbook.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
